/* rtl/core/positional_array_list_defines.svh */
// Assertion macros for the positional array list checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Clocked check, muted while reset is asserted
`define PAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define PAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/pal_pkg.sv */
// Shared types, codes and constants for the positional array list.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pal_pkg;

  // Fixed field widths and default depth
  localparam int unsigned PAL_DEPTH = 128;
  localparam int unsigned PAL_ACT_W = 3;
  localparam int unsigned PAL_POS_W = 7;
  localparam int unsigned PAL_VAL_W = 32;
  localparam int unsigned PAL_LEN_W = 8;

  // Action codes
  localparam logic [PAL_ACT_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [PAL_ACT_W-1:0] ACT_APPEND  = 3'd1;
  localparam logic [PAL_ACT_W-1:0] ACT_DELETE  = 3'd2;
  localparam logic [PAL_ACT_W-1:0] ACT_REPLACE = 3'd3;
  localparam logic [PAL_ACT_W-1:0] ACT_READ    = 3'd4;
  localparam logic [PAL_ACT_W-1:0] ACT_CLEAR   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Request and response items
  typedef struct packed {
    logic [PAL_ACT_W-1:0]        action;
    logic [PAL_POS_W-1:0]        position;
    logic signed [PAL_VAL_W-1:0] value;
  } pal_req_t;

  typedef struct packed {
    logic signed [PAL_VAL_W-1:0] result_value;
    logic [PAL_LEN_W-1:0]        list_length;
    logic [1:0]                  status;
  } pal_rsp_t;

  // Datapath selects
  typedef enum logic [1:0] {RA_POS, RA_IDX_M1, RA_IDX_P1} rd_sel_e;
  typedef enum logic {WA_POS, WA_IDX} wr_sel_e;
  typedef enum logic {WD_VAL, WD_RDATA} wd_sel_e;
  typedef enum logic [1:0] {RES_ZERO, RES_VAL, RES_CNT, RES_RDATA} res_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load_req;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    wd_sel_e  wd_sel;
    logic     idx_load_cnt;
    logic     idx_load_pos;
    logic     idx_dec;
    logic     idx_inc;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cnt_clr;
    logic     res_load;
    res_sel_e res_sel;
    logic     st_load;
    logic     out_load;
  } pal_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [PAL_ACT_W-1:0] act;
    logic [1:0]           code;
    logic                 no_shift;
    logic                 up_more;
    logic                 dn_more;
    logic                 del_more;
  } pal_stat_t;

endpackage

/* rtl/core/pal_datapath.sv */
// Datapath of the positional array list: entry memory, length, index and result registers.
// Depends on pal_pkg; driven by pal_ctrl through pal_cmd_t.
`timescale 1ns / 1ps

module pal_datapath import pal_pkg::*; #(
  parameter int unsigned DEPTH = PAL_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pal_req_t  req_i,
  input  pal_cmd_t  cmd_i,
  output pal_stat_t stat_o,
  output pal_rsp_t  rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned XW = ((CW > PAL_POS_W) ? CW : PAL_POS_W) + 1;

  logic [PAL_ACT_W-1:0]        act_q;
  logic [XW-1:0]               pos_q;
  logic signed [PAL_VAL_W-1:0] val_q;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               idx_q;
  logic signed [PAL_VAL_W-1:0] res_q;
  logic [1:0]                  st_q;
  pal_rsp_t                    rsp_q;
  logic [PAL_VAL_W-1:0]        rdata_q;
  logic [PAL_VAL_W-1:0]        mem [DEPTH];

  logic [XW-1:0]        cnt_x, idx_x, depth_x;
  logic [CW-1:0]        idx_m1, idx_p1;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [PAL_VAL_W-1:0] wr_data;
  logic [1:0]           code;

  assign cnt_x   = XW'(count_q);
  assign idx_x   = XW'(idx_q);
  assign depth_x = XW'(DEPTH);
  assign idx_m1  = idx_q - CW'(1);
  assign idx_p1  = idx_q + CW'(1);

  // Request capture; append resolves to the current length
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      act_q <= req_i.action;
      val_q <= req_i.value;
      if (req_i.action == ACT_APPEND) begin
        pos_q <= cnt_x;
      end else begin
        pos_q <= XW'(req_i.position);
      end
    end
  end

  // Status of the captured request against the current length
  always_comb begin
    code = ST_OK;
    case (act_q)
      ACT_INSERT, ACT_APPEND: begin
        if (cnt_x >= depth_x) code = ST_FULL;
        else if (pos_q > cnt_x) code = ST_RANGE;
      end
      ACT_DELETE, ACT_REPLACE, ACT_READ: begin
        if (count_q == '0) code = ST_EMPTY;
        else if (pos_q >= cnt_x) code = ST_RANGE;
      end
      default: code = ST_OK;
    endcase
  end

  assign stat_o.act      = act_q;
  assign stat_o.code     = code;
  assign stat_o.no_shift = (pos_q == cnt_x);
  assign stat_o.up_more  = (idx_x > pos_q + XW'(1));
  assign stat_o.dn_more  = (idx_x + XW'(2) < cnt_x);
  assign stat_o.del_more = (pos_q + XW'(1) < cnt_x);

  // Memory address and data selection
  always_comb begin
    case (cmd_i.rd_sel)
      RA_POS:    rd_addr = pos_q[AW-1:0];
      RA_IDX_M1: rd_addr = idx_m1[AW-1:0];
      RA_IDX_P1: rd_addr = idx_p1[AW-1:0];
      default:   rd_addr = pos_q[AW-1:0];
    endcase
    wr_addr = (cmd_i.wr_sel == WA_IDX) ? idx_q[AW-1:0] : pos_q[AW-1:0];
    wr_data = (cmd_i.wd_sel == WD_RDATA) ? rdata_q : val_q;
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // List length
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) count_d = '0;
    else if (cmd_i.cnt_inc) count_d = count_q + CW'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Shift index
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_load_cnt) idx_q <= count_q;
    else if (cmd_i.idx_load_pos) idx_q <= pos_q[CW-1:0];
    else if (cmd_i.idx_dec) idx_q <= idx_m1;
    else if (cmd_i.idx_inc) idx_q <= idx_p1;
  end

  // Result value and status
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_ZERO:  res_q <= '0;
        RES_VAL:   res_q <= val_q;
        RES_CNT:   res_q <= PAL_VAL_W'(count_q);
        RES_RDATA: res_q <= rdata_q;
        default:   res_q <= '0;
      endcase
    end
    if (cmd_i.st_load) begin
      st_q <= code;
    end
  end

  // Output register; length taken after the update
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q.result_value <= res_q;
      rsp_q.list_length  <= cnt_x[PAL_LEN_W-1:0];
      rsp_q.status       <= st_q;
    end
  end

  assign rsp_o = rsp_q;

endmodule

/* rtl/core/pal_ctrl.sv */
// Controller of the positional array list: sequences memory reads, writes and shifts.
// Depends on pal_pkg; drives pal_datapath through pal_cmd_t.
`timescale 1ns / 1ps

module pal_ctrl import pal_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pal_stat_t stat_i,
  output pal_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_SH_RD   = 4'd2;
  localparam logic [3:0] S_SH_WR   = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_RD_WAIT = 4'd5;
  localparam logic [3:0] S_DEL_CAP = 4'd6;
  localparam logic [3:0] S_DEL_RD  = 4'd7;
  localparam logic [3:0] S_DEL_WR  = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d            = state_q;
    cmd_o.load_req     = 1'b0;
    cmd_o.rd_en        = 1'b0;
    cmd_o.rd_sel       = RA_POS;
    cmd_o.wr_en        = 1'b0;
    cmd_o.wr_sel       = WA_POS;
    cmd_o.wd_sel       = WD_VAL;
    cmd_o.idx_load_cnt = 1'b0;
    cmd_o.idx_load_pos = 1'b0;
    cmd_o.idx_dec      = 1'b0;
    cmd_o.idx_inc      = 1'b0;
    cmd_o.cnt_inc      = 1'b0;
    cmd_o.cnt_dec      = 1'b0;
    cmd_o.cnt_clr      = 1'b0;
    cmd_o.res_load     = 1'b0;
    cmd_o.res_sel      = RES_ZERO;
    cmd_o.st_load      = 1'b0;
    cmd_o.out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.st_load = 1'b1;
        if (stat_i.code != ST_OK) begin
          // failed request: list untouched, zero result
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ZERO;
          state_d        = S_FIN;
        end else begin
          case (stat_i.act)
            ACT_INSERT, ACT_APPEND: begin
              if (stat_i.no_shift) begin
                state_d = S_INS_WR;
              end else begin
                cmd_o.idx_load_cnt = 1'b1;
                state_d            = S_SH_RD;
              end
            end
            ACT_DELETE: begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_DEL_CAP;
            end
            ACT_REPLACE: begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_VAL;
              state_d        = S_FIN;
            end
            ACT_READ: begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_RD_WAIT;
            end
            ACT_CLEAR: begin
              cmd_o.cnt_clr  = 1'b1;
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_CNT;
              state_d        = S_FIN;
            end
            default: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_ZERO;
              state_d        = S_FIN;
            end
          endcase
        end
      end
      // move entry idx-1 up to idx
      S_SH_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_IDX_M1;
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WA_IDX;
        cmd_o.wd_sel  = WD_RDATA;
        cmd_o.idx_dec = 1'b1;
        state_d       = stat_i.up_more ? S_SH_RD : S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_VAL;
        state_d        = S_FIN;
      end
      S_RD_WAIT: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_RDATA;
        state_d        = S_FIN;
      end
      S_DEL_CAP: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_RDATA;
        if (stat_i.del_more) begin
          cmd_o.idx_load_pos = 1'b1;
          state_d            = S_DEL_RD;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end
      end
      // move entry idx+1 down to idx
      S_DEL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_IDX_P1;
        state_d      = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WA_IDX;
        cmd_o.wd_sel  = WD_RDATA;
        cmd_o.idx_inc = 1'b1;
        if (stat_i.dn_more) begin
          state_d = S_DEL_RD;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/positional_array_list.sv */
// Channel   Handshake                Payload
// in        in_valid_i / in_ready_o  in_req_i   (pal_req_t: action, position, value)
// out       out_valid_o / out_ready_i out_rsp_o (pal_rsp_t: result_value, list_length, status)
//
// Items are handled one at a time; in_ready_o is high only while idle. Insert moves
// count - position entries up, delete moves count - position - 1 down, and other requests
// move none. Each moved entry costs one read and one write of the single-port-read entry
// memory. Reset clears the length and control; entries are not cleared. A stalled output
// holds the finished item while the next one is accepted.
`timescale 1ns / 1ps

module positional_array_list import pal_pkg::*; #(
  parameter int unsigned DEPTH = PAL_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pal_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pal_rsp_t out_rsp_o
);

  pal_cmd_t  cmd;
  pal_stat_t stat;

  // Sequencer
  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and result path
  pal_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (out_rsp_o)
  );

endmodule

/* rtl/core/pal_checker.sv */
// Port-level checks for the positional array list, bound to the top level.
// Depends on pal_pkg and positional_array_list_defines.svh.
`timescale 1ns / 1ps
`include "positional_array_list_defines.svh"

module pal_checker import pal_pkg::*; #(
  parameter int unsigned DEPTH = PAL_DEPTH
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pal_rsp_t out_rsp_o
);

  localparam logic [PAL_LEN_W-1:0] DepthLen = PAL_LEN_W'(DEPTH);

  // A result waiting to be taken stays put
  `PAL_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o),
    "result dropped or changed while stalled")

  // The input is not ready in the cycle after an item is accepted
  `PAL_ASSERT(a_busy_after_accept,
    in_valid_i && in_ready_o |=> !in_ready_o,
    "item accepted on consecutive cycles")

  // A failed request carries a zero value
  `PAL_ASSERT(a_fail_zero,
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.result_value == '0,
    "failed request returned a value")

  // Empty and full reports agree with the length
  `PAL_ASSERT(a_len_status,
    out_valid_o && (out_rsp_o.status == ST_EMPTY || out_rsp_o.status == ST_FULL) |->
      out_rsp_o.list_length == ((out_rsp_o.status == ST_EMPTY) ? '0 : DepthLen),
    "length disagrees with status")

  // No result is shown out of reset
  `PAL_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind positional_array_list pal_checker #(
  .DEPTH (DEPTH)
) u_pal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
